### hdl/sequenced_square_voice_assert.svh
// Assertion macros for the square voice; clk and rst_n come from the using module.
`ifndef SEQUENCED_SQUARE_VOICE_ASSERT_SVH
`define SEQUENCED_SQUARE_VOICE_ASSERT_SVH

// Same-cycle implication.
`define SSV_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SSV_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### hdl/ssv_pkg.sv
// Shared types, codes and the note period table of the square voice.
package ssv_pkg;
  localparam int NOTE_COUNT = 84;

  typedef logic [2:0] opcode_t;
  localparam opcode_t OP_SAMPLE   = 3'd0;
  localparam opcode_t OP_NOTE_ON  = 3'd1;
  localparam opcode_t OP_NOTE_OFF = 3'd2;
  localparam opcode_t OP_WR_FREQ  = 3'd3;
  localparam opcode_t OP_WR_VOL   = 3'd4;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SPT      = 3'd0;
  localparam cfg_idx_t CFG_SCALE    = 3'd1;
  localparam cfg_idx_t CFG_VSTEP    = 3'd2;
  localparam cfg_idx_t CFG_VIB_SPD  = 3'd3;
  localparam cfg_idx_t CFG_VIB_DEP  = 3'd4;
  localparam cfg_idx_t CFG_VIB_DLY  = 3'd5;
  localparam cfg_idx_t CFG_FREQ_LEN = 3'd6;
  localparam cfg_idx_t CFG_VOL_LEN  = 3'd7;

  localparam logic signed [7:0] SEQ_LOOP  = -8'sd32;
  localparam logic signed [7:0] SEQ_END   = -8'sd31;
  localparam logic signed [7:0] SEQ_WAIT  = -8'sd24;
  localparam logic signed [7:0] SEQ_HOLD_LO = -8'sd31;
  localparam logic signed [7:0] SEQ_HOLD_HI = -8'sd25;

  localparam logic [12:0] PERIOD_MIN = 13'd113;
  localparam logic [12:0] PERIOD_MAX = 13'd6848;
  localparam logic [23:0] PHASE_ONE  = 24'h010000;

  function automatic logic [12:0] note_period(input logic [6:0] idx);
    logic [12:0] p;
    case (idx)
      7'd0: p = 13'd1712;  7'd1: p = 13'd1616;  7'd2: p = 13'd1524;  7'd3: p = 13'd1440;
      7'd4: p = 13'd1356;  7'd5: p = 13'd1280;  7'd6: p = 13'd1208;  7'd7: p = 13'd1140;
      7'd8: p = 13'd1076;  7'd9: p = 13'd1016;  7'd10: p = 13'd960;  7'd11: p = 13'd906;
      7'd12: p = 13'd856;  7'd13: p = 13'd808;  7'd14: p = 13'd762;  7'd15: p = 13'd720;
      7'd16: p = 13'd678;  7'd17: p = 13'd640;  7'd18: p = 13'd604;  7'd19: p = 13'd570;
      7'd20: p = 13'd538;  7'd21: p = 13'd508;  7'd22: p = 13'd480;  7'd23: p = 13'd453;
      7'd24: p = 13'd428;  7'd25: p = 13'd404;  7'd26: p = 13'd381;  7'd27: p = 13'd360;
      7'd28: p = 13'd339;  7'd29: p = 13'd320;  7'd30: p = 13'd302;  7'd31: p = 13'd285;
      7'd32: p = 13'd269;  7'd33: p = 13'd254;  7'd34: p = 13'd240;  7'd35: p = 13'd226;
      7'd36: p = 13'd214;  7'd37: p = 13'd202;  7'd38: p = 13'd190;  7'd39: p = 13'd180;
      7'd40: p = 13'd170;  7'd41: p = 13'd160;  7'd42: p = 13'd151;  7'd43: p = 13'd143;
      7'd44: p = 13'd135;  7'd45: p = 13'd127;  7'd46: p = 13'd120;
      7'd60: p = 13'd3424; 7'd61: p = 13'd3232; 7'd62: p = 13'd3048; 7'd63: p = 13'd2880;
      7'd64: p = 13'd2712; 7'd65: p = 13'd2560; 7'd66: p = 13'd2416; 7'd67: p = 13'd2280;
      7'd68: p = 13'd2152; 7'd69: p = 13'd2032; 7'd70: p = 13'd1920; 7'd71: p = 13'd1812;
      7'd72: p = 13'd6848; 7'd73: p = 13'd6464; 7'd74: p = 13'd6096; 7'd75: p = 13'd5760;
      7'd76: p = 13'd5424; 7'd77: p = 13'd5120; 7'd78: p = 13'd4832; 7'd79: p = 13'd4560;
      7'd80: p = 13'd4304; 7'd81: p = 13'd4064; 7'd82: p = 13'd3840; 7'd83: p = 13'd3624;
      default: p = PERIOD_MIN;
    endcase
    return p;
  endfunction
endpackage

### hdl/ssv_in_if.sv
// Input channel of the square voice.
interface ssv_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic [6:0]        note_number;
  logic [9:0]        table_index;
  logic signed [7:0] table_value;
  modport source (output valid, opcode, note_number, table_index, table_value, input ready);
  modport sink (input valid, opcode, note_number, table_index, table_value, output ready);
endinterface

### hdl/ssv_out_if.sv
// Result channel of the square voice.
interface ssv_out_if;
  logic              valid;
  logic              ready;
  logic signed [6:0] sample_value;
  logic [12:0]       current_period;
  logic [5:0]        current_volume;
  logic              is_playing;
  modport source (output valid, sample_value, current_period, current_volume, is_playing,
                  input ready);
  modport sink (input valid, sample_value, current_period, current_volume, is_playing,
                output ready);
endinterface

### hdl/sequenced_square_voice.sv
// Square voice: sequenced FSM over two sequence memories (one read port each).
// Writes, note off and idle samples pass through execute and done; a sample without a tick
// adds the phase state; note on adds multiply and half; a sample with a tick also runs the
// serial frequency and volume table walks and the period update before multiply and half.
// One item at a time; the next is taken once the result is in the output register.
// rst_n is synchronous; sequence memories are not cleared and hold garbage until written.
module sequenced_square_voice #(
  parameter int TABLE_DEPTH = 1024,
  parameter int WALK_LIMIT  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  ssv_in_if.sink      in_ch,
  ssv_out_if.source   out_ch,
  input  logic        cfg_we,
  input  ssv_pkg::cfg_idx_t cfg_index,
  input  logic [23:0] cfg_data
);
  import ssv_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(TABLE_DEPTH + 2);
  localparam int WW = $clog2(WALK_LIMIT + 1);

  localparam logic [4:0] S_IDLE  = 5'd0,  S_EXEC  = 5'd1,  S_FCHK  = 5'd2,
                         S_FSTEP = 5'd3,  S_FEV   = 5'd4,  S_FLINK = 5'd5,
                         S_FWAIT = 5'd6,  S_VCHK  = 5'd7,  S_VSTEP = 5'd8,
                         S_VEV   = 5'd9,  S_VLINK = 5'd10, S_VSUS  = 5'd11,
                         S_PER   = 5'd12, S_MUL   = 5'd13, S_HALF  = 5'd14,
                         S_PHASE = 5'd15, S_DONE  = 5'd16;

  // configuration
  logic [15:0] spt_r;
  logic [23:0] scale_r;
  logic [7:0]  vstep_r, vib_spd_r, vib_dep_r, vib_dly_r;
  logic [10:0] flen_cfg_r, vlen_cfg_r;

  // voice state
  logic [4:0]  state_r;
  logic [WW-1:0] walk_r;
  opcode_t     op_r;
  logic [6:0]  note_r;
  logic [9:0]  tidx_r;
  logic [7:0]  tval_r;
  logic        playing_r, pol_r, vib_rising_r, vib_skip_r;
  logic [6:0]  base_r;
  logic [15:0] tick_cnt_r;
  logic [23:0] phase_r, half_r;
  logic [PW-1:0] fpos_r, vpos_r;
  logic [7:0]  fwait_r, vcnt_r, vsus_r, vib_wait_r;
  logic signed [7:0] transpose_r;
  logic [5:0]  volume_r;
  logic [9:0]  vib_off_r;
  logic [12:0] period_r;
  logic [36:0] prod_r;
  logic signed [6:0] sample_r;

  logic        out_valid_r;
  logic signed [6:0] out_sample_r;
  logic [12:0] out_period_r;
  logic [5:0]  out_volume_r;
  logic        out_playing_r;

  // memories
  logic [7:0]  freq_mem [TABLE_DEPTH];
  logic [7:0]  vol_mem [TABLE_DEPTH];
  logic [7:0]  frd_r, vrd_r;
  logic [AW-1:0] f_raddr, v_raddr;
  logic        wr_ok;

  // combinational helpers
  logic [PW-1:0] flen, vlen;
  logic [PW:0]   fpos_p1, vpos_p1;
  logic          fhas_next, vhas_next, walk_last;
  logic signed [7:0] fv, vv;
  logic [5:0]    vtgt;
  logic [6:0]    on_idx;
  logic signed [8:0] note_idx;
  logic [12:0]   tab_period;
  logic [6:0]    speed;
  logic          skip_nxt, rising_nxt;
  logic signed [10:0] off_sum, off_nxt, depth2;
  logic signed [14:0] per_sum;
  logic [12:0]   period_nxt;
  logic [28:0]   half_sh;
  logic [23:0]   half_nxt;
  logic [24:0]   ph_add, ph_sub;
  logic [23:0]   phase_nxt;
  logic          pol_flip;
  logic [16:0]   cnt_inc;

  assign flen = ({21'd0, flen_cfg_r} > TABLE_DEPTH) ? PW'(TABLE_DEPTH) : PW'(flen_cfg_r);
  assign vlen = ({21'd0, vlen_cfg_r} > TABLE_DEPTH) ? PW'(TABLE_DEPTH) : PW'(vlen_cfg_r);
  assign fpos_p1 = {1'b0, fpos_r} + (PW+1)'(1);
  assign vpos_p1 = {1'b0, vpos_r} + (PW+1)'(1);
  assign fhas_next = fpos_p1 < {1'b0, flen};
  assign vhas_next = vpos_p1 < {1'b0, vlen};
  assign walk_last = ({1'b0, walk_r} + (WW+1)'(1)) >= (WW+1)'(WALK_LIMIT);
  assign fv = $signed(frd_r);
  assign vv = $signed(vrd_r);
  assign vtgt = vrd_r[5:0];
  assign wr_ok = {22'd0, tidx_r} < TABLE_DEPTH;

  always_comb begin
    f_raddr = fpos_r[AW-1:0];
    v_raddr = vpos_r[AW-1:0];
    if (state_r == S_FEV) f_raddr = fpos_p1[AW-1:0];
    if (state_r == S_VEV) v_raddr = vpos_p1[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && op_r == OP_WR_FREQ && wr_ok) freq_mem[AW'(tidx_r)] <= tval_r;
    if (state_r == S_EXEC && op_r == OP_WR_VOL && wr_ok) vol_mem[AW'(tidx_r)] <= tval_r;
    frd_r <= freq_mem[f_raddr];
    vrd_r <= vol_mem[v_raddr];
  end

  // note on index and tick period with vibrato
  always_comb begin
    on_idx = (note_r < 7'd24) ? 7'd0 : ((note_r > 7'd107) ? 7'd83 : note_r - 7'd24);
    note_idx = $signed({2'b00, base_r}) + {transpose_r[7], transpose_r};
    if (note_idx < 0 || note_idx >= 9'sd84) tab_period = note_period(7'd0);
    else tab_period = note_period(note_idx[6:0]);

    speed = vib_spd_r[6:0];
    skip_nxt = vib_spd_r[7] ? ~vib_skip_r : vib_skip_r;
    rising_nxt = vib_rising_r;
    depth2 = $signed({2'b00, vib_dep_r, 1'b0});
    off_nxt = $signed({1'b0, vib_off_r});
    off_sum = vib_rising_r ? off_nxt + $signed({4'd0, speed})
                           : off_nxt - $signed({4'd0, speed});
    if (!skip_nxt) begin
      if (vib_rising_r) begin
        off_nxt = off_sum;
        if (off_sum >= depth2) begin
          rising_nxt = 1'b0;
          off_nxt = depth2;
        end
      end else begin
        off_nxt = off_sum;
        if (off_sum < 0) begin
          rising_nxt = 1'b1;
          off_nxt = '0;
        end
      end
    end
    // table periods are at least 113, so the low-period doubling never applies
    per_sum = $signed({2'b00, tab_period});
    if (vib_wait_r == 8'd0 && vib_dep_r != 8'd0)
      per_sum = per_sum + 15'(off_nxt) - $signed({7'd0, vib_dep_r});
    if (per_sum < $signed({2'b00, PERIOD_MIN})) period_nxt = PERIOD_MIN;
    else if (per_sum > $signed({2'b00, PERIOD_MAX})) period_nxt = PERIOD_MAX;
    else period_nxt = per_sum[12:0];
  end

  always_comb begin
    half_sh = prod_r[36:8];
    if (half_sh > 29'h0FFFFFF) half_nxt = 24'hFFFFFF;
    else if (half_sh < {5'd0, PHASE_ONE}) half_nxt = PHASE_ONE;
    else half_nxt = half_sh[23:0];
    ph_add = {1'b0, phase_r} + {1'b0, PHASE_ONE};
    pol_flip = ph_add >= {1'b0, half_r};
    ph_sub = pol_flip ? ph_add - {1'b0, half_r} : ph_add;
    phase_nxt = ph_sub[24] ? 24'hFFFFFF : ph_sub[23:0];
    cnt_inc = {1'b0, tick_cnt_r} + 17'd1;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.sample_value = out_sample_r;
  assign out_ch.current_period = out_period_r;
  assign out_ch.current_volume = out_volume_r;
  assign out_ch.is_playing = out_playing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r <= 16'd960; scale_r <= 24'd113536; vstep_r <= 8'd1;
      vib_spd_r <= '0; vib_dep_r <= '0; vib_dly_r <= '0;
      flen_cfg_r <= '0; vlen_cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPT:      spt_r <= cfg_data[15:0];
        CFG_SCALE:    scale_r <= cfg_data;
        CFG_VSTEP:    vstep_r <= cfg_data[7:0];
        CFG_VIB_SPD:  vib_spd_r <= cfg_data[7:0];
        CFG_VIB_DEP:  vib_dep_r <= cfg_data[7:0];
        CFG_VIB_DLY:  vib_dly_r <= cfg_data[7:0];
        CFG_FREQ_LEN: flen_cfg_r <= cfg_data[10:0];
        CFG_VOL_LEN:  vlen_cfg_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; walk_r <= '0; out_valid_r <= 1'b0;
      playing_r <= 1'b0; base_r <= '0; tick_cnt_r <= '0; phase_r <= '0;
      half_r <= '0; pol_r <= 1'b1; fpos_r <= '0; fwait_r <= '0;
      transpose_r <= '0; vpos_r <= '0; vcnt_r <= 8'd1; vsus_r <= '0;
      volume_r <= '0; vib_wait_r <= '0; vib_off_r <= '0; vib_rising_r <= 1'b1;
      vib_skip_r <= 1'b0; period_r <= '0; sample_r <= '0;
    end else begin
      // the done state loads the output register itself
      if (out_valid_r && out_ch.ready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r <= in_ch.opcode; note_r <= in_ch.note_number;
            tidx_r <= in_ch.table_index; tval_r <= in_ch.table_value;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          sample_r <= '0;
          state_r <= S_DONE;
          case (op_r)
            OP_SAMPLE: begin
              if (playing_r) begin
                if (cnt_inc >= {1'b0, spt_r}) begin
                  tick_cnt_r <= '0;
                  state_r <= S_FCHK;
                end else begin
                  tick_cnt_r <= cnt_inc[15:0];
                  state_r <= S_PHASE;
                end
              end
            end
            OP_NOTE_ON: begin
              base_r <= on_idx; playing_r <= 1'b1; phase_r <= '0; pol_r <= 1'b1;
              tick_cnt_r <= '0; fpos_r <= '0; fwait_r <= '0; transpose_r <= '0;
              vpos_r <= '0; vsus_r <= '0; vcnt_r <= 8'd1; volume_r <= '0;
              vib_wait_r <= vib_dly_r; vib_off_r <= '0; vib_rising_r <= 1'b1;
              vib_skip_r <= 1'b0; period_r <= note_period(on_idx);
              state_r <= S_MUL;
            end
            OP_NOTE_OFF: playing_r <= 1'b0;
            default: ;
          endcase
        end
        S_FCHK: begin
          walk_r <= '0;
          if (fwait_r != 8'd0) begin
            fwait_r <= fwait_r - 8'd1;
            state_r <= S_VCHK;
          end else state_r <= S_FSTEP;
        end
        S_FSTEP: begin
          if (fpos_r >= flen) begin
            fpos_r <= '0;
            state_r <= S_VCHK;
          end else state_r <= S_FEV;
        end
        S_FEV: begin
          if (fv == SEQ_LOOP && fhas_next) state_r <= S_FLINK;
          else if (fv == SEQ_LOOP || fv == SEQ_END) begin
            fpos_r <= '0;
            walk_r <= walk_r + WW'(1);
            state_r <= walk_last ? S_VCHK : S_FSTEP;
          end else if (fv == SEQ_WAIT) begin
            if (fhas_next) state_r <= S_FWAIT;
            else begin
              fpos_r <= fpos_r + PW'(2);
              state_r <= S_VCHK;
            end
          end else begin
            transpose_r <= fv;
            fpos_r <= fpos_p1[PW-1:0];
            state_r <= S_VCHK;
          end
        end
        S_FLINK: begin
          fpos_r <= PW'(frd_r[5:0]);
          walk_r <= walk_r + WW'(1);
          state_r <= walk_last ? S_VCHK : S_FSTEP;
        end
        S_FWAIT: begin
          fwait_r <= frd_r;
          fpos_r <= fpos_r + PW'(2);
          state_r <= S_VCHK;
        end
        S_VCHK: begin
          walk_r <= '0;
          state_r <= S_PER;
          if (vsus_r != 8'd0) vsus_r <= vsus_r - 8'd1;
          else if (vcnt_r <= 8'd1) begin
            vcnt_r <= (vstep_r == 8'd0) ? 8'd1 : vstep_r;
            state_r <= S_VSTEP;
          end else vcnt_r <= vcnt_r - 8'd1;
        end
        S_VSTEP: begin
          if (vpos_r >= vlen) begin
            vpos_r <= '0;
            state_r <= S_PER;
          end else state_r <= S_VEV;
        end
        S_VEV: begin
          if (vv >= SEQ_HOLD_LO && vv <= SEQ_HOLD_HI) state_r <= S_PER;
          else if (vv == SEQ_LOOP && vhas_next) state_r <= S_VLINK;
          else if (vv == SEQ_LOOP) begin
            vpos_r <= '0;
            walk_r <= walk_r + WW'(1);
            state_r <= walk_last ? S_PER : S_VSTEP;
          end else if (vv == SEQ_WAIT) begin
            if (vhas_next) state_r <= S_VSUS;
            else begin
              vpos_r <= vpos_r + PW'(2);
              state_r <= S_PER;
            end
          end else begin
            volume_r <= vv[7] ? 6'd0 : ((vv > 8'sd63) ? 6'd63 : vv[5:0]);
            vpos_r <= vpos_p1[PW-1:0];
            state_r <= S_PER;
          end
        end
        S_VLINK: begin
          vpos_r <= (vtgt < 6'd5) ? '0 : PW'(vtgt - 6'd5);
          walk_r <= walk_r + WW'(1);
          state_r <= walk_last ? S_PER : S_VSTEP;
        end
        S_VSUS: begin
          vsus_r <= vrd_r;
          vpos_r <= vpos_r + PW'(2);
          state_r <= S_PER;
        end
        S_PER: begin
          if (vib_wait_r != 8'd0) vib_wait_r <= vib_wait_r - 8'd1;
          else if (vib_dep_r != 8'd0) begin
            vib_skip_r <= skip_nxt;
            vib_rising_r <= rising_nxt;
            vib_off_r <= off_nxt[9:0];
          end
          period_r <= period_nxt;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r <= {24'd0, period_r} * {13'd0, scale_r};
          state_r <= S_HALF;
        end
        S_HALF: begin
          half_r <= half_nxt;
          state_r <= (op_r == OP_SAMPLE) ? S_PHASE : S_DONE;
        end
        S_PHASE: begin
          phase_r <= phase_nxt;
          if (pol_flip) pol_r <= ~pol_r;
          sample_r <= (pol_r ^ pol_flip) ? $signed({1'b0, volume_r})
                                         : -$signed({1'b0, volume_r});
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_sample_r <= sample_r;
            out_period_r <= period_r;
            out_volume_r <= volume_r;
            out_playing_r <= playing_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`include "sequenced_square_voice_assert.svh"
  `SSV_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, state_r != S_IDLE)
  `SSV_ASSERT_IMP(a_period_range, 1'b1, period_r <= PERIOD_MAX)
  `SSV_ASSERT_IMP(a_half_floor, state_r == S_PHASE, half_r >= PHASE_ONE)
  `SSV_ASSERT_IMP(a_walk_bound, 1'b1, {1'b0, walk_r} <= (WW+1)'(WALK_LIMIT))
endmodule
